// File: rtl/pqmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqmf_pkg;

    // Action codes carried in the input word.
    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_PEEK    = 2'd1;
    localparam logic [1:0] ACT_DEQUEUE = 2'd2;

    // Status codes carried in the result word.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] item_value;
        logic [7:0]         item_priority;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic [7:0]         out_priority;
        logic [3:0]         fill_count;
    } out_word_t;

    // Running best entry that travels down the cell chain.
    typedef struct packed {
        logic               found;
        logic [7:0]         priority_best;
        logic signed [31:0] value_best;
    } scan_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic write_en;
        logic remove_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/pqmf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pqmf_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 3,
    parameter int CNT_W = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pqmf_pkg::cell_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]    fill,
    input  wire logic [IDX_W-1:0]    remove_idx,
    input  wire logic signed [31:0]  write_value,
    input  wire logic [7:0]          write_priority,
    input  wire logic signed [31:0]  next_value,
    input  wire logic [7:0]          next_priority,
    input  wire pqmf_pkg::scan_t     scan_in,
    input  wire logic [IDX_W-1:0]    scan_in_idx,
    output pqmf_pkg::scan_t          scan_out,
    output logic [IDX_W-1:0]         scan_out_idx,
    output logic signed [31:0]       value,
    output logic [7:0]               priority_val
);

    logic signed [31:0]  value_reg;
    logic signed [31:0]  value_next;
    logic [7:0]          priority_reg;
    logic [7:0]          priority_next;
    pqmf_pkg::scan_t     scan_reg;
    pqmf_pkg::scan_t     scan_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                occupied;
    logic                take;

    assign occupied = (CNT_W'(INDEX) < fill);

    // Strictly greater keeps the oldest entry among equal priorities.
    assign take = occupied && (!scan_in.found || (priority_reg > scan_in.priority_best));

    always_comb
    begin
        if (take)
        begin
            scan_next.found         = 1'b1;
            scan_next.priority_best = priority_reg;
            scan_next.value_best    = value_reg;
            idx_next                = IDX_W'(INDEX);
        end
        else
        begin
            scan_next = scan_in;
            idx_next  = scan_in_idx;
        end
    end

    // An enqueue lands in the first free cell; a removal pulls every cell at
    // or behind the removed slot forward by one place.
    always_comb
    begin
        value_next    = value_reg;
        priority_next = priority_reg;
        if (ctrl.write_en && (fill == CNT_W'(INDEX)))
        begin
            value_next    = write_value;
            priority_next = write_priority;
        end
        else if (ctrl.remove_en && (IDX_W'(INDEX) >= remove_idx))
        begin
            value_next    = next_value;
            priority_next = next_priority;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            idx_reg  <= idx_next;
        end
    end

    assign scan_out     = scan_reg;
    assign scan_out_idx = idx_reg;
    assign value        = value_reg;
    assign priority_val = priority_reg;

endmodule

`default_nettype wire

// File: rtl/priority_queue_max_first.sv
// Channel  | Valid          | Stall          | Word
// ---------+----------------+----------------+------------------------------
// Request  | item_valid     | item_stall     | item_word   (pqmf_pkg::in_word_t)
// Result   | result_valid   | result_stall   | result_word (pqmf_pkg::out_word_t)
//
// One word is handled at a time. An enqueue is taken into the operation register and
// written to the result register as soon as that is free; a peek or a dequeue also waits
// for the best-entry scan, which moves one cell down the chain each cycle. The controller
// returns to idle as the result is written, so the next word can be accepted even while
// that result waits. A stalled result holds the next operation in the controller until the
// output register frees up. Reset clears fill count, control and scan state, not entries.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_max_first #(
    parameter int DEPTH = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire pqmf_pkg::in_word_t item_word,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output pqmf_pkg::out_word_t     result_word
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // The controller has two states: waiting for a request, and executing one.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    pqmf_pkg::in_word_t  op_reg;
    pqmf_pkg::in_word_t  op_next;
    logic [IDX_W-1:0]    wait_reg;
    logic [IDX_W-1:0]    wait_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    pqmf_pkg::out_word_t out_reg;
    pqmf_pkg::out_word_t out_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                out_free;
    logic                scan_done;
    logic                op_ready;
    logic                commit;
    pqmf_pkg::cell_ctrl_t ctrl;
    pqmf_pkg::out_word_t result_calc;
    logic [CNT_W-1:0]    count_after;
    logic                write_req;
    logic                remove_req;

    pqmf_pkg::scan_t     scan_w [DEPTH+1];
    logic [IDX_W-1:0]    idx_w  [DEPTH+1];
    logic signed [31:0]  value_w [DEPTH];
    logic [7:0]          prio_w  [DEPTH];

    assign scan_w[0] = '0;
    assign idx_w[0]  = '0;

    // The chain of entry cells. Cell 0 holds the oldest entry. The scan
    // enters at cell 0 with nothing found and leaves the last cell holding
    // the oldest entry of highest priority and its slot index.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] nb_value;
        logic [7:0]         nb_prio;

        if (i < DEPTH - 1)
        begin : g_mid
            assign nb_value = value_w[i+1];
            assign nb_prio  = prio_w[i+1];
        end
        else
        begin : g_last
            assign nb_value = value_w[i];
            assign nb_prio  = prio_w[i];
        end

        pqmf_cell #(
            .INDEX (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .fill           (count_reg),
            .remove_idx     (idx_w[DEPTH]),
            .write_value    (op_reg.item_value),
            .write_priority (op_reg.item_priority),
            .next_value     (nb_value),
            .next_priority  (nb_prio),
            .scan_in        (scan_w[i]),
            .scan_in_idx    (idx_w[i]),
            .scan_out       (scan_w[i+1]),
            .scan_out_idx   (idx_w[i+1]),
            .value          (value_w[i]),
            .priority_val   (prio_w[i])
        );
    end

    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);

    // The store is stable from one commit to the next, so once the wait counter marks the
    // scan done, the scan at the end of the chain reflects the current store.
    assign scan_done = (wait_reg == IDX_W'(DEPTH - 1));
    assign op_ready  = ((op_reg.action != pqmf_pkg::ACT_PEEK)
                        && (op_reg.action != pqmf_pkg::ACT_DEQUEUE)) || scan_done;
    assign commit    = (state_reg == S_EXEC) && op_ready && out_free;

    always_comb
    begin
        result_calc = '0;
        count_after = count_reg;
        write_req   = 1'b0;
        remove_req  = 1'b0;
        case (op_reg.action)
            pqmf_pkg::ACT_ENQUEUE:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    result_calc.status = pqmf_pkg::ST_FULL;
                end
                else
                begin
                    result_calc.status = pqmf_pkg::ST_DONE;
                    count_after        = count_reg + CNT_W'(1);
                    write_req          = 1'b1;
                end
            end
            pqmf_pkg::ACT_PEEK:
            begin
                if (count_reg == '0)
                begin
                    result_calc.status = pqmf_pkg::ST_EMPTY;
                end
                else
                begin
                    result_calc.status       = pqmf_pkg::ST_DONE;
                    result_calc.out_priority = scan_w[DEPTH].priority_best;
                end
            end
            pqmf_pkg::ACT_DEQUEUE:
            begin
                if (count_reg == '0)
                begin
                    result_calc.status = pqmf_pkg::ST_EMPTY;
                end
                else
                begin
                    result_calc.status       = pqmf_pkg::ST_DONE;
                    result_calc.out_value    = scan_w[DEPTH].value_best;
                    result_calc.out_priority = scan_w[DEPTH].priority_best;
                    count_after              = count_reg - CNT_W'(1);
                    remove_req               = 1'b1;
                end
            end
            default:
            begin
                result_calc.status = pqmf_pkg::ST_DONE;
            end
        endcase
        result_calc.fill_count = 4'(count_after);
    end

    assign ctrl = '{write_en: commit && write_req, remove_en: commit && remove_req};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next    = item_word;
                    wait_next  = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!scan_done)
                begin
                    wait_next = wait_reg + IDX_W'(1);
                end
                if (commit)
                begin
                    out_next       = result_calc;
                    out_valid_next = 1'b1;
                    count_next     = count_after;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_reg;

endmodule

`default_nettype wire

// File: rtl/pqmf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pqmf_checker #(
    parameter int DEPTH = 8
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_stall,
    input wire logic                result_valid,
    input wire logic                result_stall,
    input wire pqmf_pkg::out_word_t result_word
);

    // A stalled result word stays on the port unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("stalled result word changed");

    // Requests are served one at a time, so an accepted word closes the port.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request accepted while another is in progress");

    // A refused enqueue only happens with the store full.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.status == pqmf_pkg::ST_FULL)
        |-> result_word.fill_count == 4'(DEPTH))
        else $error("full status with a store that is not full");

    // An empty status comes with an empty store and no returned data.
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_word.status == pqmf_pkg::ST_EMPTY)
        |-> (result_word.fill_count == 4'd0) && (result_word.out_value == 32'sd0)
            && (result_word.out_priority == 8'd0))
        else $error("empty status with data or a nonzero fill count");

    // For stores of up to 15 entries, the reported fill count never goes beyond the store size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (DEPTH > 15) || (result_word.fill_count <= 4'(DEPTH)))
        else $error("fill count beyond the store size");

endmodule

bind priority_queue_max_first pqmf_checker #(.DEPTH(DEPTH)) u_pqmf_checker (.*);

`default_nettype wire
